>>> rtl/core/acl_pkg.sv
`default_nettype none
package acl_pkg;

  // A 4-bit slot index reaches at most this many rules.
  localparam int MAX_RULES     = 16;
  localparam int DEF_NUM_RULES = 16;

  localparam int ACT_W   = 2;
  localparam int RIDX_W  = 4;
  localparam int VER_W   = 4;
  localparam int PROTO_W = 9;
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 17;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 8;

  localparam logic [VER_W-1:0]   IP_VERSION_4 = 4'd4;
  localparam logic [PROTO_W-1:0] PROTO_TCP    = 9'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP    = 9'd17;
  localparam logic [PROTO_W-1:0] PROTO_ANY    = '1;
  localparam logic [PORT_W-1:0]  PORT_ANY     = '1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLASSIFY   = 2'd0,
    ACT_WRITE      = 2'd1,
    ACT_INVALIDATE = 2'd2
  } action_t;

  // Stored rule body; the valid bit lives apart so that reset can clear it.
  typedef struct packed {
    logic               dir;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  src_mask;
    logic [ADDR_W-1:0]  dst_addr;
    logic [ADDR_W-1:0]  dst_mask;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
  } rule_t;

  // Header key as held in the input stage.
  typedef struct packed {
    logic               dir;
    logic               ver_ok;
    logic               is_l4;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  src_addr;
    logic [ADDR_W-1:0]  dst_addr;
    logic [PORT_W-1:0]  src_port;
    logic [PORT_W-1:0]  dst_port;
  } key_t;

  function automatic logic rule_hit(rule_t r, key_t k);
    logic ok;
    ok = (r.dir == k.dir);
    ok = ok && ((r.proto == PROTO_ANY) || (r.proto == k.proto));
    ok = ok && ((r.src_addr & r.src_mask) == (k.src_addr & r.src_mask));
    ok = ok && ((r.dst_addr & r.dst_mask) == (k.dst_addr & r.dst_mask));
    if (k.is_l4) begin
      ok = ok && ((r.src_port == PORT_ANY) || (r.src_port == k.src_port));
      ok = ok && ((r.dst_port == PORT_ANY) || (r.dst_port == k.dst_port));
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/acl_rule_table.sv
`default_nettype none
module acl_rule_table #(
  parameter int NUM_SLOTS = acl_pkg::MAX_RULES
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   wr_en,
  input  wire logic                                   inval_en,
  input  wire logic [acl_pkg::RIDX_W-1:0]             wr_idx,
  input  wire acl_pkg::rule_t                         wr_rule,
  output logic [NUM_SLOTS-1:0]                        rule_valid,
  output acl_pkg::rule_t [NUM_SLOTS-1:0]              rules
);
  import acl_pkg::*;

  logic [NUM_SLOTS-1:0]  valid_r;
  logic [NUM_SLOTS-1:0]  valid_nxt;
  rule_t [NUM_SLOTS-1:0] body_r;

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (wr_idx == RIDX_W'(i)) begin
        if (wr_en) begin
          valid_nxt[i] = 1'b1;
        end else if (inval_en) begin
          valid_nxt[i] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Indexes at or beyond the slot count match no slot and drop silently.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (wr_en && (wr_idx == RIDX_W'(i))) begin
        body_r[i] <= wr_rule;
      end
    end
  end

  assign rule_valid = valid_r;
  assign rules      = body_r;

endmodule
`default_nettype wire

>>> rtl/core/acl_match_stage.sv
`default_nettype none
module acl_match_stage #(
  parameter int NUM_SLOTS = acl_pkg::MAX_RULES
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire acl_pkg::key_t                          key,
  input  wire logic [NUM_SLOTS-1:0]                   rule_valid,
  input  wire acl_pkg::rule_t [NUM_SLOTS-1:0]         rules,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic                                        ver_ok,
  output logic [NUM_SLOTS-1:0]                        hits
);
  import acl_pkg::*;

  logic                 valid_r;
  logic                 ver_ok_r;
  logic [NUM_SLOTS-1:0] hits_r;
  logic [NUM_SLOTS-1:0] hits_nxt;

  // One compare lane per rule slot.
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      hits_nxt[i] = rule_valid[i] && rule_hit(rules[i], key);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hits_r   <= hits_nxt;
      ver_ok_r <= key.ver_ok;
    end
  end

  assign out_valid = valid_r;
  assign ver_ok    = ver_ok_r;
  assign hits      = hits_r;

endmodule
`default_nettype wire

>>> rtl/core/ipv4_acl_first_match_classifier.sv
`default_nettype none
// Channel   Dir  Handshake            Payload
// --------  ---  -------------------  ---------------------------------------------
// in_       in   in_tvalid/in_tready  tuser: action; tdata: rule and header fields
// out_      out  out_tvalid/out_tready tdata: block verdict, one per classify
//
// Cycles: one request may enter every cycle while in_tready is high.
// A classify request passes the input, compare and reduce stages to its
// verdict. Writes and invalidates update the table at the accepting edge.
// Reset: synchronous, active low; clears all valid bits, input ready at once.
// Stalls: a stage holds while the next is full and stalled; bubbles collapse,
// and in_tready drops only when the input stage is held.
module ipv4_acl_first_match_classifier #(
  parameter int NUM_RULES = acl_pkg::DEF_NUM_RULES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [1:0] action
  input  wire logic [acl_pkg::ACT_W-1:0]         in_tuser,
  // [3:0] rule_index, [4] direction, [8:5] ip_version, [17:9] protocol,
  // [49:18] src_address, [81:50] src_mask, [113:82] dst_address,
  // [145:114] dst_mask, [162:146] src_port, [179:163] dst_port, [183:180] zero
  input  wire logic [acl_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [0] block, [7:1] zero
  output logic [acl_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import acl_pkg::*;

  // Slots beyond what the index can address could never be written.
  localparam int NUM_SLOTS = (NUM_RULES < MAX_RULES) ? NUM_RULES : MAX_RULES;

  // Field views of the incoming request.
  action_t              in_action;
  logic [RIDX_W-1:0]    in_rule_index;
  logic                 in_direction;
  logic [VER_W-1:0]     in_ip_version;
  logic [PROTO_W-1:0]   in_protocol;
  logic [ADDR_W-1:0]    in_src_address;
  logic [ADDR_W-1:0]    in_src_mask;
  logic [ADDR_W-1:0]    in_dst_address;
  logic [ADDR_W-1:0]    in_dst_mask;
  logic [PORT_W-1:0]    in_src_port;
  logic [PORT_W-1:0]    in_dst_port;

  assign in_action      = action_t'(in_tuser);
  assign in_rule_index  = in_tdata[3:0];
  assign in_direction   = in_tdata[4];
  assign in_ip_version  = in_tdata[8:5];
  assign in_protocol    = in_tdata[17:9];
  assign in_src_address = in_tdata[49:18];
  assign in_src_mask    = in_tdata[81:50];
  assign in_dst_address = in_tdata[113:82];
  assign in_dst_mask    = in_tdata[145:114];
  assign in_src_port    = in_tdata[162:146];
  assign in_dst_port    = in_tdata[179:163];

  logic in_accept;
  logic is_classify;
  logic wr_en;
  logic inval_en;

  assign in_accept = in_tvalid && in_tready;

  // Decode the request kind; the unused code falls through and is dropped.
  always_comb begin
    is_classify = 1'b0;
    wr_en       = 1'b0;
    inval_en    = 1'b0;
    case (in_action)
      ACT_CLASSIFY:   is_classify = in_accept;
      ACT_WRITE:      wr_en       = in_accept;
      ACT_INVALIDATE: inval_en    = in_accept;
      default: begin
        is_classify = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Rule table: written at the accepting edge, so a classify already in
  // the input stage compares against the table as it stood before.
  // ---------------------------------------------------------------------
  rule_t                 wr_rule;
  logic [NUM_SLOTS-1:0]  rule_valid;
  rule_t [NUM_SLOTS-1:0] rules;

  always_comb begin
    wr_rule.dir      = in_direction;
    wr_rule.proto    = in_protocol;
    wr_rule.src_addr = in_src_address;
    wr_rule.src_mask = in_src_mask;
    wr_rule.dst_addr = in_dst_address;
    wr_rule.dst_mask = in_dst_mask;
    wr_rule.src_port = in_src_port;
    wr_rule.dst_port = in_dst_port;
  end

  acl_rule_table #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .inval_en   (inval_en),
    .wr_idx     (in_rule_index),
    .wr_rule    (wr_rule),
    .rule_valid (rule_valid),
    .rules      (rules)
  );

  // ---------------------------------------------------------------------
  // Stage 1: register the header key. Only classify requests occupy it.
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  key_t s1_key_r;
  key_t s1_key_nxt;
  logic s2_in_ready;

  assign in_tready = !s1_valid_r || s2_in_ready;

  always_comb begin
    s1_key_nxt.dir      = in_direction;
    s1_key_nxt.ver_ok   = (in_ip_version == IP_VERSION_4);
    // Protocols outside 0..255 carry the sign bit and never hit TCP or UDP.
    s1_key_nxt.is_l4    = (in_protocol == PROTO_TCP) || (in_protocol == PROTO_UDP);
    s1_key_nxt.proto    = in_protocol;
    s1_key_nxt.src_addr = in_src_address;
    s1_key_nxt.dst_addr = in_dst_address;
    s1_key_nxt.src_port = in_src_port;
    s1_key_nxt.dst_port = in_dst_port;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= is_classify;
    end
  end

  always_ff @(posedge clk) begin
    if (is_classify) begin
      s1_key_r <= s1_key_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: per-rule compare lanes, hit vector registered.
  // ---------------------------------------------------------------------
  logic                 s2_valid;
  logic                 s2_ver_ok;
  logic [NUM_SLOTS-1:0] s2_hits;
  logic                 s3_ready;

  acl_match_stage #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_valid_r),
    .in_ready   (s2_in_ready),
    .key        (s1_key_r),
    .rule_valid (rule_valid),
    .rules      (rules),
    .out_valid  (s2_valid),
    .out_ready  (s3_ready),
    .ver_ok     (s2_ver_ok),
    .hits       (s2_hits)
  );

  // ---------------------------------------------------------------------
  // Stage 3: reduce hits to one verdict and hold it for the consumer.
  // Any hit blocks; a non-IPv4 header always passes.
  // ---------------------------------------------------------------------
  logic out_valid_r;
  logic out_block_r;
  logic out_block_nxt;

  assign s3_ready      = !out_valid_r || out_tready;
  assign out_block_nxt = s2_ver_ok && (|s2_hits);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      out_block_r <= out_block_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_block_r};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_from_stage2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s2_valid))
    else $error("verdict appeared without a compared header behind it");

  a_non_ipv4_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid && s3_ready && !s2_ver_ok) |=> (out_tvalid && !out_tdata[0]))
    else $error("non-IPv4 header produced a block verdict");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_WRITE) && (in_tdata[3:0] == 4'd0))
      |=> rule_valid[0])
    else $error("rule write did not set the slot valid bit");

  a_inval_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ACT_INVALIDATE) && (in_tdata[3:0] == 4'd0))
      |=> !rule_valid[0])
    else $error("rule invalidate did not clear the slot valid bit");

endmodule
`default_nettype wire

>>> tb/acl_verdict_checker.sv
`default_nettype none
module acl_verdict_checker #(
  parameter int NUM_RULES = acl_pkg::DEF_NUM_RULES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  // [1:0] action
  input  wire logic [acl_pkg::ACT_W-1:0]      in_tuser,
  // [3:0] rule_index, [4] direction, [8:5] ip_version, [17:9] protocol,
  // [49:18] src_address, [81:50] src_mask, [113:82] dst_address,
  // [145:114] dst_mask, [162:146] src_port, [179:163] dst_port, [183:180] zero
  input  wire logic [acl_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] block, [7:1] zero
  input  wire logic [acl_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                                  mismatches,
  output int                                  verdicts_pending
);
  import acl_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  logic  rule_live [NUM_RULES];
  rule_t rule_body [NUM_RULES];
  logic  expected_block [$];

  function automatic rule_t unpack_fields(logic [IN_DATA_W-1:0] d);
    rule_t f;
    f.dir      = d[4];
    f.proto    = d[17:9];
    f.src_addr = d[49:18];
    f.src_mask = d[81:50];
    f.dst_addr = d[113:82];
    f.dst_mask = d[145:114];
    f.src_port = d[162:146];
    f.dst_port = d[179:163];
    return f;
  endfunction

  // First-match search; any hit blocks the header, a non-IPv4 header passes.
  function automatic logic table_verdict(logic [IN_DATA_W-1:0] d);
    rule_t h;
    rule_t r;
    logic  l4;
    int    i;
    h  = unpack_fields(d);
    l4 = (h.proto == PROTO_TCP) || (h.proto == PROTO_UDP);
    if (d[8:5] != IP_VERSION_4) return 1'b0;
    for (i = 0; i < NUM_RULES; i++) begin
      r = rule_body[i];
      if (rule_live[i] && r.dir == h.dir &&
          (r.proto == PROTO_ANY || r.proto == h.proto) &&
          ((r.src_addr & r.src_mask) == (h.src_addr & r.src_mask)) &&
          ((r.dst_addr & r.dst_mask) == (h.dst_addr & r.dst_mask)) &&
          (!l4 || ((r.src_port == PORT_ANY || r.src_port == h.src_port) &&
                   (r.dst_port == PORT_ANY || r.dst_port == h.dst_port))))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    logic [RIDX_W-1:0]     slot;
    logic [OUT_DATA_W-1:0] want;
    int                    i;
    if (!rst_n) begin
      for (i = 0; i < NUM_RULES; i++) rule_live[i] = 1'b0;
      expected_block.delete();
      verdicts_pending = 0;
    end else begin
      // Check the verdict before queuing a new request taken at the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_block.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("verdict with no classify request pending: got %02h", out_tdata);
        end else begin
          want = {{(OUT_DATA_W-1){1'b0}}, expected_block.pop_front()};
          if (out_tdata !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("verdict mismatch: expected %02h, got %02h", want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        slot = in_tdata[RIDX_W-1:0];
        case (in_tuser)
          ACT_CLASSIFY: expected_block.push_back(table_verdict(in_tdata));
          ACT_WRITE: begin
            if (slot < NUM_RULES) begin
              rule_body[slot] = unpack_fields(in_tdata);
              rule_live[slot] = 1'b1;
            end
          end
          ACT_INVALIDATE: begin
            if (slot < NUM_RULES) rule_live[slot] = 1'b0;
          end
          default: ;
        endcase
      end
      verdicts_pending = expected_block.size();
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  import acl_pkg::*;

  localparam int NUM_RULES    = DEF_NUM_RULES;
  localparam int RANDOM_ITEMS = 400;
  // Last stretch of the run: no gaps from the sender, no stalls at the sink.
  localparam int QUIET_ITEMS  = 60;
  // Margin after the last pending verdict, to watch for strays.
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_LIMIT   = 1000;
  // Action code the block must ignore.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ACT_W-1:0]      in_tuser;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    verdicts_pending;
  int                    idle_cycles;
  bit                    quiet;

  // Rules as last written, used only to aim headers at them.
  rule_t sent_rules   [NUM_RULES];
  bit    sent_written [NUM_RULES];

  ipv4_acl_first_match_classifier #(
    .NUM_RULES (NUM_RULES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  acl_verdict_checker #(
    .NUM_RULES (NUM_RULES)
  ) verdict_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tuser         (in_tuser),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatches       (mismatches),
    .verdicts_pending (verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Present one request, hold it until accepted, then maybe drop valid for
  // a random burst.
  task automatic push(input logic [ACT_W-1:0] act, input logic [RIDX_W-1:0] idx,
                      input logic dir, input logic [VER_W-1:0] ver,
                      input logic [PROTO_W-1:0] proto,
                      input logic [ADDR_W-1:0] sa, sm, da, dm,
                      input logic [PORT_W-1:0] sp, dp);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    // Top four bits are padding and stay zero.
    in_tdata  <= {4'b0, dp, sp, dm, da, sm, sa, proto, ver, dir, idx};
    do @(posedge clk); while (!in_tready);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic write_rule(input logic [RIDX_W-1:0] idx, input logic dir,
                            input logic [PROTO_W-1:0] proto,
                            input logic [ADDR_W-1:0] sa, sm, da, dm,
                            input logic [PORT_W-1:0] sp, dp);
    sent_rules[idx].dir      = dir;
    sent_rules[idx].proto    = proto;
    sent_rules[idx].src_addr = sa;
    sent_rules[idx].src_mask = sm;
    sent_rules[idx].dst_addr = da;
    sent_rules[idx].dst_mask = dm;
    sent_rules[idx].src_port = sp;
    sent_rules[idx].dst_port = dp;
    sent_written[idx]        = 1'b1;
    // Version nibble is don't-care on a write; randomize it.
    push(ACT_WRITE, idx, dir, VER_W'($urandom), proto, sa, sm, da, dm, sp, dp);
  endtask

  // Index and masks are unused on classify; keep them toggling.
  task automatic classify(input logic dir, input logic [VER_W-1:0] ver,
                          input logic [PROTO_W-1:0] proto,
                          input logic [ADDR_W-1:0] sa, da,
                          input logic [PORT_W-1:0] sp, dp);
    push(ACT_CLASSIFY, RIDX_W'($urandom), dir, ver, proto, sa, $urandom, da, $urandom,
         sp, dp);
  endtask

  task automatic invalidate(input logic [RIDX_W-1:0] idx);
    push(ACT_INVALIDATE, idx, 1'($urandom), VER_W'($urandom), PROTO_W'($urandom),
         $urandom, $urandom, $urandom, $urandom, PORT_W'($urandom), PORT_W'($urandom));
  endtask

  // Mostly prefix masks, plus empty, full and scattered ones.
  function automatic logic [ADDR_W-1:0] rand_mask();
    int len;
    len = $urandom_range(0, 40);
    if (len > ADDR_W) return $urandom;
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic logic [PROTO_W-1:0] rand_rule_proto();
    case ($urandom_range(0, 3))
      0:       return PROTO_ANY;
      1:       return PROTO_TCP;
      2:       return PROTO_UDP;
      default: return PROTO_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] rand_rule_port();
    if ($urandom_range(0, 4) < 2) return PORT_ANY;
    return PORT_W'($urandom_range(0, 65535));
  endfunction

  // Header protocol leans on TCP and UDP so ports get tested; -1 shows rarely.
  function automatic logic [PROTO_W-1:0] rand_header_proto();
    case ($urandom_range(0, 9))
      0, 1, 2: return PROTO_TCP;
      3, 4, 5: return PROTO_UDP;
      6:       return PROTO_ANY;
      default: return PROTO_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [PORT_W-1:0] rand_header_port();
    if ($urandom_range(0, 19) == 0) return PORT_ANY;
    return PORT_W'($urandom_range(0, 65535));
  endfunction

  // Aim most headers at a written rule (live or invalidated), then maybe
  // knock one field off; the rest are free-running headers.
  task automatic random_classify();
    rule_t              r;
    int                 slot;
    logic               dir;
    logic [VER_W-1:0]   ver;
    logic [PROTO_W-1:0] proto;
    logic [ADDR_W-1:0]  sa;
    logic [ADDR_W-1:0]  da;
    logic [PORT_W-1:0]  sp;
    logic [PORT_W-1:0]  dp;
    slot = $urandom_range(0, NUM_RULES - 1);
    if (sent_written[slot] && $urandom_range(0, 9) < 7) begin
      r     = sent_rules[slot];
      dir   = r.dir;
      ver   = IP_VERSION_4;
      proto = (r.proto == PROTO_ANY) ? rand_header_proto() : r.proto;
      sa    = (r.src_addr & r.src_mask) | ($urandom & ~r.src_mask);
      da    = (r.dst_addr & r.dst_mask) | ($urandom & ~r.dst_mask);
      sp    = (r.src_port == PORT_ANY) ? rand_header_port() : r.src_port;
      dp    = (r.dst_port == PORT_ANY) ? rand_header_port() : r.dst_port;
      case ($urandom_range(0, 13))
        0: dir   = ~dir;
        1: ver   = VER_W'($urandom_range(0, 15));
        2: proto = rand_header_proto();
        3: sa    = sa ^ (32'h1 << $urandom_range(0, 31));
        4: da    = da ^ (32'h1 << $urandom_range(0, 31));
        5: sp    = sp + 1'b1;
        6: dp    = dp + 1'b1;
        default: ;
      endcase
    end else begin
      dir   = 1'($urandom);
      ver   = ($urandom_range(0, 3) == 0) ? VER_W'($urandom_range(0, 15)) : IP_VERSION_4;
      proto = rand_header_proto();
      sa    = $urandom;
      da    = $urandom;
      sp    = rand_header_port();
      dp    = rand_header_port();
    end
    classify(dir, ver, proto, sa, da, sp, dp);
  endtask

  // Sink: random stall bursts, calm stretches, always ready once quiet.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 19) < 3) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: abort when neither channel moves a request for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int sent;
    int pick;
    quiet       = 1'b0;
    sent        = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= '0;
    in_tdata   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table right after reset: pass.
    classify(1'b0, IP_VERSION_4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 1234, 80);
    // Catch-all inbound rule in the lowest slot.
    write_rule(0, 1'b0, PROTO_ANY, '0, '0, '0, '0, PORT_ANY, PORT_ANY);
    classify(1'b0, IP_VERSION_4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 1234, 80);
    // Non-IPv4 headers always pass, whatever the table holds.
    classify(1'b0, 4'd5, PROTO_TCP, 32'h0A000001, 32'h0A000002, 1234, 80);
    classify(1'b0, 4'd0, PROTO_UDP, '0, '0, 0, 0);
    classify(1'b0, 4'hF, PROTO_UDP, '1, '1, 17'hFFFF, 17'hFFFF);
    // Wrong direction misses.
    classify(1'b1, IP_VERSION_4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 1234, 80);
    // Invalidate drops the rule.
    invalidate(0);
    classify(1'b0, IP_VERSION_4, PROTO_TCP, 32'h0A000001, 32'h0A000002, 1234, 80);
    // Unused action: no verdict expected.
    push(ACT_UNUSED, '1, 1'b1, '1, '1, '1, '1, '1, '1, 17'hFFFF, 17'hFFFF);
    // Outbound TCP rule in the top slot: /16 source, exact destination, port 80.
    write_rule(15, 1'b1, PROTO_TCP, 32'hC0A80000, 32'hFFFF0000, 32'hFFFFFFFF,
               32'hFFFFFFFF, PORT_ANY, 80);
    classify(1'b1, IP_VERSION_4, PROTO_TCP, 32'hC0A8FFFF, 32'hFFFFFFFF, 17'hFFFF, 80);
    classify(1'b1, IP_VERSION_4, PROTO_TCP, 32'hC0A8FFFF, 32'hFFFFFFFF, 17'hFFFF, 81);
    classify(1'b1, IP_VERSION_4, PROTO_TCP, 32'hC0A90000, 32'hFFFFFFFF, 0, 80);
    // Non-TCP/UDP protocol: ports never compared.
    write_rule(7, 1'b1, 9'd1, 32'h01020304, 32'hFFFFFFFF, 32'h05060708,
               32'hFFFFFFFF, 5, 5);
    classify(1'b1, IP_VERSION_4, 9'd1, 32'h01020304, 32'h05060708, 0, 17'hFFFF);
    // Header port of -1 only equals a rule port of -1.
    write_rule(3, 1'b0, PROTO_UDP, '0, '0, '0, '0, 0, PORT_ANY);
    classify(1'b0, IP_VERSION_4, PROTO_UDP, '0, '0, PORT_ANY, 53);
    classify(1'b0, IP_VERSION_4, PROTO_UDP, '1, '0, 0, 53);
    // Header protocol -1 is not L4; matches a wildcard-protocol rule.
    write_rule(4, 1'b0, PROTO_ANY, '0, '0, '0, '0, 0, 0);
    classify(1'b0, IP_VERSION_4, PROTO_ANY, 32'h12345678, 32'h9ABCDEF0, 1, 1);
    classify(1'b0, IP_VERSION_4, PROTO_TCP, 32'h12345678, 32'h9ABCDEF0, 1, 1);
    invalidate(3);
    invalidate(4);

    // Random mix: mostly headers aimed at rules, with rule churn in between.
    while (sent < RANDOM_ITEMS) begin
      quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
      pick  = $urandom_range(0, 99);
      if (pick < 3) begin
        push(ACT_UNUSED, RIDX_W'($urandom), 1'($urandom), VER_W'($urandom),
             PROTO_W'($urandom), $urandom, $urandom, $urandom, $urandom,
             PORT_W'($urandom), PORT_W'($urandom));
      end else begin
        if (pick < 20)
          write_rule(RIDX_W'($urandom), 1'($urandom), rand_rule_proto(), $urandom,
                     rand_mask(), $urandom, rand_mask(), rand_rule_port(),
                     rand_rule_port());
        else if (pick < 26)
          invalidate(RIDX_W'($urandom));
        else
          random_classify();
        sent++;
      end
    end

    // Drain: wait out every pending verdict, then watch for strays.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> ipv4_acl_first_match_classifier.f
rtl/core/acl_pkg.sv
rtl/core/acl_rule_table.sv
rtl/core/acl_match_stage.sv
rtl/core/ipv4_acl_first_match_classifier.sv
tb/acl_verdict_checker.sv
tb/testbench.sv
